### hdl/smsb_pkg.sv
// ----------------------------------------------------------------------------
// smsb_pkg
// Shared types and constants of the scancode matrix serial bridge.
// ----------------------------------------------------------------------------
package smsb_pkg;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ADDR  = 2'd1,
        PH_GAP   = 2'd2,
        PH_DATA  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_START_PHASE = 3'd0,
        REG_SETUP       = 3'd1,
        REG_CLOCK_HIGH  = 3'd2,
        REG_BIT_TAIL    = 3'd3,
        REG_GAP         = 3'd4
    } cfg_reg_t;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 8;
    localparam int NIB_W       = 4;
    localparam int FRAME_W     = 5;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CNT_W  = 3;
    localparam int OUT_W       = 3;

    localparam logic [CFG_W-1:0] START_PHASE_RST = 8'd6;
    localparam logic [CFG_W-1:0] SETUP_RST       = 8'd6;
    localparam logic [CFG_W-1:0] CLOCK_HIGH_RST  = 8'd12;
    localparam logic [CFG_W-1:0] BIT_TAIL_RST    = 8'd21;
    localparam logic [CFG_W-1:0] GAP_RST         = 8'd54;

    localparam logic [NIB_W-1:0] FIRST_ADDR = 4'hF;
    localparam logic [7:0]       KEY_NONE   = 8'hFF;

    localparam logic [7:0] CODE_MAP [128] = '{
        KEY_NONE, 8'h20, KEY_NONE, 8'hA0, 8'h00, 8'h02, KEY_NONE, 8'h12,
        KEY_NONE, 8'h03, 8'hA4, KEY_NONE, KEY_NONE, 8'h84, 8'h26, KEY_NONE,
        KEY_NONE, 8'hA7, 8'h26, KEY_NONE, 8'hA1, 8'h83, 8'h80, KEY_NONE,
        KEY_NONE, KEY_NONE, 8'h87, 8'h74, 8'h85, 8'h73, 8'h81, KEY_NONE,
        KEY_NONE, 8'h76, 8'h77, 8'h75, 8'h72, 8'h70, 8'h71, KEY_NONE,
        KEY_NONE, 8'h57, 8'h67, 8'h65, 8'h63, 8'h62, 8'h61, KEY_NONE,
        KEY_NONE, 8'h56, 8'h66, 8'h54, 8'h64, 8'h53, 8'h60, KEY_NONE,
        KEY_NONE, KEY_NONE, 8'h46, 8'h55, 8'h52, 8'h51, 8'h50, KEY_NONE,
        KEY_NONE, KEY_NONE, 8'h45, 8'h43, 8'h42, 8'h40, 8'h41, KEY_NONE,
        KEY_NONE, 8'h37, 8'h23, 8'h44, 8'h35, 8'h33, 8'h31, KEY_NONE,
        KEY_NONE, KEY_NONE, KEY_NONE, 8'h11, 8'h32, 8'h30, KEY_NONE, KEY_NONE,
        8'h86, 8'h25, 8'h22, 8'h21, 8'h36, 8'h34, KEY_NONE, KEY_NONE,
        KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, 8'h97, KEY_NONE,
        KEY_NONE, 8'h17, KEY_NONE, 8'h15, 8'h24, KEY_NONE, KEY_NONE, KEY_NONE,
        8'h01, 8'hA6, 8'h07, 8'h16, 8'h05, 8'h14, 8'h82, 8'hA5,
        8'h13, 8'h27, 8'h06, 8'hA3, 8'hA2, 8'h04, 8'h10, KEY_NONE
    };

    typedef struct packed {
        logic             valid;
        logic             is_key;
        logic             released;
        logic             key_hit;
        logic             ignored;
        logic [2:0]       bit_sel;
        logic [NIB_W-1:0] row;
        logic             row_valid;
        logic             fwd;
        logic [7:0]       fwd_data;
    } s1_item_t;

endpackage

### hdl/scancode_matrix_serial_bridge_unit.sv
// ----------------------------------------------------------------------------
// scancode_matrix_serial_bridge_unit
// Key matrix in RAM updated by key events; tick items clock out frames.
// A result passes through the stage-1 register and the result queue before it
// appears on m_tdata.
// Throughput: one item per cycle while the result queue has room for it.
// Reset: synchronous, active low; clears row valid bits, sequencer, output
// queue and restores register defaults. No RAM clearing pass.
// ----------------------------------------------------------------------------
module scancode_matrix_serial_bridge_unit #(
    parameter int ROWS       = 16,
    parameter int TABLE_SIZE = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] scancode, [8] key_released
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] data_line, [1] clock_line, [2] key_ignored
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [7:0] start_phase_reg, setup_reg, clock_high_reg, bit_tail_reg, gap_reg;

    smsb_pkg::phase_t                phase_reg, phase_next;
    logic [smsb_pkg::FRAME_W-1:0]    frame_reg, frame_next;
    logic [2:0]                      bit_reg, bit_next;
    logic [1:0]                      step_reg, step_next;
    logic [7:0]                      time_reg, time_next;
    logic                            cur_bit_reg, cur_bit_next;

    smsb_pkg::s1_item_t s1_reg, s1_next;
    logic [ROWS-1:0]    row_valid_reg;

    logic [smsb_pkg::OUT_W-1:0]      fifo_reg [smsb_pkg::FIFO_DEPTH];
    logic [smsb_pkg::FIFO_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [smsb_pkg::FIFO_CNT_W-1:0] fifo_count_reg;

    logic                            s_accept, m_accept;
    logic                            in_key, in_released;
    logic [7:0]                      in_code, in_entry;
    logic [smsb_pkg::NIB_W-1:0]      rd_row, next_row;
    logic [AW-1:0]                   rd_addr;

    logic [7:0]                      ram_rdata, row_data, frame_byte, new_row;
    logic                            ram_we;
    logic [AW-1:0]                   wr_addr;
    logic [smsb_pkg::NIB_W-1:0]      frame_addr;
    logic                            frame_exists;
    logic [7:0]                      seg_len, seg_raw;
    logic [8:0]                      tick_count;
    logic [2:0]                      bit_dec;
    logic                            data_lvl, clk_lvl;
    logic [smsb_pkg::OUT_W-1:0]      result;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_phase_reg <= smsb_pkg::START_PHASE_RST;
            setup_reg       <= smsb_pkg::SETUP_RST;
            clock_high_reg  <= smsb_pkg::CLOCK_HIGH_RST;
            bit_tail_reg    <= smsb_pkg::BIT_TAIL_RST;
            gap_reg         <= smsb_pkg::GAP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smsb_pkg::REG_START_PHASE: start_phase_reg <= cfg_data;
                smsb_pkg::REG_SETUP:       setup_reg       <= cfg_data;
                smsb_pkg::REG_CLOCK_HIGH:  clock_high_reg  <= cfg_data;
                smsb_pkg::REG_BIT_TAIL:    bit_tail_reg    <= cfg_data;
                smsb_pkg::REG_GAP:         gap_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: decode, issue matrix read
    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;
    assign s_tready    = ({1'b0, fifo_count_reg} + 4'(s1_reg.valid)) < 4'(smsb_pkg::FIFO_DEPTH);
    assign in_key      = s_tuser[0];
    assign in_code     = s_tdata[7:0];
    assign in_released = s_tdata[8];
    assign in_entry    = smsb_pkg::CODE_MAP[in_code[6:0]];
    assign next_row    = (frame_next == '0) ? smsb_pkg::FIRST_ADDR
                                            : smsb_pkg::NIB_W'(frame_next - 5'd1);
    assign rd_row      = in_key ? in_entry[7:4] : next_row;
    assign rd_addr     = rd_row[AW-1:0];

    always_comb begin
        s1_next           = '0;
        s1_next.valid     = s_accept;
        s1_next.is_key    = in_key;
        s1_next.released  = in_released;
        s1_next.key_hit   = in_key && !in_code[7]
                            && ({1'b0, in_code} < 9'(TABLE_SIZE))
                            && (in_entry[3:0] < 4'd8)
                            && ({1'b0, in_entry[7:4]} < 5'(ROWS));
        s1_next.ignored   = in_key && ({1'b0, in_code} >= 9'(TABLE_SIZE));
        s1_next.bit_sel   = in_entry[2:0];
        s1_next.row       = rd_row;
        s1_next.row_valid = row_valid_reg[rd_addr];
        s1_next.fwd       = ram_we && s_accept && (rd_addr == wr_addr);
        s1_next.fwd_data  = new_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    smsb_ram #(
        .WIDTH (8),
        .DEPTH (ROWS)
    ) u_matrix (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (new_row),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // stage 1: matrix update and sequencer
    assign row_data = s1_reg.fwd ? s1_reg.fwd_data
                                 : (s1_reg.row_valid ? ram_rdata : 8'd0);
    assign new_row  = s1_reg.released ? (row_data & ~(8'd1 << s1_reg.bit_sel))
                                      : (row_data | (8'd1 << s1_reg.bit_sel));
    assign ram_we   = s1_reg.valid && s1_reg.is_key && s1_reg.key_hit;
    assign wr_addr  = s1_reg.row[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ram_we) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign frame_addr   = (frame_reg == '0) ? smsb_pkg::FIRST_ADDR
                                            : smsb_pkg::NIB_W'(frame_reg - 5'd1);
    assign frame_exists = {1'b0, frame_addr} < 5'(ROWS);
    assign frame_byte   = frame_exists ? row_data : 8'd0;
    assign tick_count   = {1'b0, time_reg} + 9'd1;
    assign bit_dec      = bit_reg - 3'd1;
    assign seg_len      = (seg_raw == 8'd0) ? 8'd1 : seg_raw;

    always_comb begin
        priority if (phase_reg == smsb_pkg::PH_GAP) begin
            seg_raw = gap_reg;
        end else if (phase_reg == smsb_pkg::PH_START) begin
            seg_raw = start_phase_reg;
        end else if (step_reg == 2'd0) begin
            seg_raw = setup_reg;
        end else if (step_reg == 2'd1) begin
            seg_raw = clock_high_reg;
        end else begin
            seg_raw = bit_tail_reg;
        end
    end

    always_comb begin
        data_lvl = 1'b0;
        clk_lvl  = 1'b0;
        unique case (phase_reg)
            smsb_pkg::PH_START: begin
                data_lvl = ~step_reg[0];
            end
            smsb_pkg::PH_ADDR, smsb_pkg::PH_DATA: begin
                data_lvl = (step_reg < 2'd2) && cur_bit_reg;
                clk_lvl  = (step_reg == 2'd1);
            end
            smsb_pkg::PH_GAP: begin
                data_lvl = 1'b0;
            end
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        frame_next   = frame_reg;
        bit_next     = bit_reg;
        step_next    = step_reg;
        time_next    = time_reg;
        cur_bit_next = cur_bit_reg;
        if (s1_reg.valid && !s1_reg.is_key) begin
            if (tick_count >= {1'b0, seg_len}) begin
                time_next = 8'd0;
                unique case (phase_reg)
                    smsb_pkg::PH_ADDR, smsb_pkg::PH_DATA: begin
                        step_next = step_reg + 2'd1;
                        if (step_reg == 2'd2) begin
                            step_next = 2'd0;
                            if (bit_reg != 3'd0) begin
                                bit_next     = bit_dec;
                                cur_bit_next = (phase_reg == smsb_pkg::PH_ADDR)
                                             ? frame_addr[bit_dec[1:0]]
                                             : frame_byte[bit_dec];
                            end else if (phase_reg == smsb_pkg::PH_ADDR) begin
                                phase_next = smsb_pkg::PH_GAP;
                            end else begin
                                frame_next = (frame_reg >= 5'(ROWS)) ? '0 : frame_reg + 5'd1;
                                phase_next = smsb_pkg::PH_START;
                            end
                        end
                    end
                    smsb_pkg::PH_GAP: begin
                        phase_next   = smsb_pkg::PH_DATA;
                        bit_next     = 3'd7;
                        step_next    = 2'd0;
                        cur_bit_next = frame_byte[7];
                    end
                    smsb_pkg::PH_START: begin
                        step_next = step_reg + 2'd1;
                        if (step_reg == 2'd3) begin
                            phase_next   = smsb_pkg::PH_ADDR;
                            bit_next     = 3'd3;
                            step_next    = 2'd0;
                            cur_bit_next = frame_addr[3];
                        end
                    end
                endcase
            end else begin
                time_next = tick_count[7:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= smsb_pkg::PH_START;
            frame_reg   <= '0;
            bit_reg     <= '0;
            step_reg    <= '0;
            time_reg    <= '0;
            cur_bit_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            frame_reg   <= frame_next;
            bit_reg     <= bit_next;
            step_reg    <= step_next;
            time_reg    <= time_next;
            cur_bit_reg <= cur_bit_next;
        end
    end

    // result queue
    assign result = {s1_reg.ignored, clk_lvl, data_lvl};

    always_ff @(posedge aclk) begin
        if (s1_reg.valid) begin
            fifo_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (s1_reg.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (m_accept) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fifo_count_reg <= fifo_count_reg + 3'(s1_reg.valid) - 3'(m_accept);
        end
    end

    assign m_tvalid = (fifo_count_reg != '0);
    assign m_tdata  = {5'd0, fifo_reg[rd_ptr_reg]};

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_reg.valid |-> (fifo_count_reg < 3'(smsb_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_write_on_key: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (s1_reg.valid && s1_reg.is_key && !s1_reg.ignored))
        else $error("matrix write without key event");

    a_fwd_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_reg.fwd |-> ($past(ram_we) && s1_reg.valid))
        else $error("forwarded row without preceding write");

    a_start_clock_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == smsb_pkg::PH_START || phase_reg == smsb_pkg::PH_GAP) |-> !clk_lvl)
        else $error("clock line high outside a bit");
`endif

endmodule

### hdl/smsb_ram.sv
// ----------------------------------------------------------------------------
// smsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
